// File: src/rlepw_pkg.sv
// Package for the run-length voxel table with point writes.
// Holds widths, command/status/operation codes and the structs shared by
// the cell and the top level. Depends on nothing.
`default_nettype none
package rlepw_pkg;

  localparam int MAX_RUNS = 256;
  localparam int POS_W    = $clog2(MAX_RUNS);     // run index
  localparam int CNT_W    = POS_W + 1;            // run count 0..MAX_RUNS
  localparam int VOX_W    = 16;
  localparam int LEN_W    = 16;
  localparam int LIM_W    = LEN_W + POS_W;        // cumulative run end
  localparam int EDGE_W   = 6;
  localparam int CRD_W    = 5;
  localparam int T1_W     = 11;                   // x*e + y
  localparam int LIN_W    = 17;                   // (x*e + y)*e + z
  localparam int IN_W     = 64;
  localparam int OUT_W    = 48;

  localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(16);
  localparam logic [LEN_W-1:0]  LEN_FULL   = '1;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_BAD_RUN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_APPEND,
    OP_INS_BEFORE,
    OP_TAIL_MERGE,
    OP_TAIL_INS,
    OP_SPLIT
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX1,
    S_IDX2,
    S_FIND,
    S_DEC,
    S_APPLY,
    S_DONE
  } state_e;

  localparam logic [0:0] CFG_EDGE = 1'b0;
  localparam logic [0:0] CFG_DFLT = 1'b1;

  // One run as held in a cell: id, length and cumulative end index
  typedef struct packed {
    logic [VOX_W-1:0] vox;
    logic [LEN_W-1:0] len;
    logic [LIM_W-1:0] lim;
  } cell_t;

  // Lookup broadcast to all cells
  typedef struct packed {
    logic [LIM_W-1:0] idx;
    logic [CNT_W-1:0] total;
    logic [POS_W-1:0] sel;
    logic             rd;
  } lk_t;

  // Update broadcast to all cells
  typedef struct packed {
    op_e              op;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] rem;
    logic [LIM_W-1:0] start;
    logic [VOX_W-1:0] vid;
    logic [LEN_W-1:0] rlen;
    logic [LIM_W-1:0] app_end;
    logic [CNT_W-1:0] total;
  } ctl_t;

endpackage
`default_nettype wire

// File: src/rlepw_cell.sv
// One cell of the run chain: holds one run and its cumulative end.
// Flags the run holding the lookup index and takes a neighbor's run on
// inserts. Depends on rlepw_pkg.
`default_nettype none
module rlepw_cell import rlepw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [POS_W-1:0] cell_idx_i,
  input  wire lk_t              lk_i,
  input  wire ctl_t             ctl_i,
  input  wire logic             apply_i,
  input  wire cell_t            prev1_i,
  input  wire cell_t            prev2_i,
  input  wire logic             prev_hit_i,
  output cell_t                 own_o,
  output logic                  hit_o,
  output logic                  pick_o
);

  cell_t            run_q, run_d;
  logic             valid;
  logic [CNT_W-1:0] j, p;

  assign j     = {1'b0, cell_idx_i};
  assign p     = {1'b0, ctl_i.pos};
  assign valid = j < lk_i.total;
  assign own_o = run_q;

  // Flag runs ending past the index; the first such one holds it
  assign hit_o  = valid && (run_q.lim > lk_i.idx);
  assign pick_o = lk_i.rd ? (valid && (cell_idx_i == lk_i.sel)) : (hit_o && !prev_hit_i);

  // Compute this cell's run after the edit
  always_comb begin
    run_d = run_q;
    case (ctl_i.op)
      OP_APPEND: begin
        if (j == ctl_i.total) begin
          run_d.vox = ctl_i.vid;
          run_d.len = ctl_i.rlen;
          run_d.lim = ctl_i.app_end;
        end
      end
      OP_INS_BEFORE: begin
        if (j == p) begin
          run_d.vox = ctl_i.vid;
          run_d.len = LEN_W'(1);
          run_d.lim = ctl_i.start + LIM_W'(1);
        end else if (j == p + CNT_W'(1)) begin
          run_d     = prev1_i;
          run_d.len = prev1_i.len - LEN_W'(1);
        end else if (j > p + CNT_W'(1)) begin
          run_d = prev1_i;
        end
      end
      OP_TAIL_MERGE: begin
        if (j == p) begin
          run_d.len = run_q.len - LEN_W'(1);
          run_d.lim = run_q.lim - LIM_W'(1);
        end else if (j == p + CNT_W'(1)) begin
          run_d.len = run_q.len + LEN_W'(1);
        end
      end
      OP_TAIL_INS: begin
        if (j == p) begin
          run_d.len = run_q.len - LEN_W'(1);
          run_d.lim = run_q.lim - LIM_W'(1);
        end else if (j == p + CNT_W'(1)) begin
          run_d.vox = ctl_i.vid;
          run_d.len = LEN_W'(1);
          run_d.lim = prev1_i.lim;
        end else if (j > p + CNT_W'(1)) begin
          run_d = prev1_i;
        end
      end
      OP_SPLIT: begin
        if (j == p) begin
          run_d.len = ctl_i.rem;
          run_d.lim = ctl_i.start + LIM_W'(ctl_i.rem);
        end else if (j == p + CNT_W'(1)) begin
          run_d.vox = ctl_i.vid;
          run_d.len = LEN_W'(1);
          run_d.lim = ctl_i.start + LIM_W'(ctl_i.rem) + LIM_W'(1);
        end else if (j == p + CNT_W'(2)) begin
          run_d     = prev2_i;
          run_d.len = prev2_i.len - ctl_i.rem - LEN_W'(1);
        end else if (j > p + CNT_W'(2)) begin
          run_d = prev2_i;
        end
      end
      default: run_d = run_q;
    endcase
  end

  // Hold the run unless an edit is applied
  always_ff @(posedge clk_i) begin
    if (apply_i) begin
      run_q <= run_d;
    end
  end

endmodule
`default_nettype wire

// File: src/rle_array_point_write_core.sv
// Top level of the run-length voxel table with point writes.
// Instantiates the chain of rlepw_cell and runs the command sequencer.
// Depends on rlepw_pkg and rlepw_cell.
//
// The table is a chain of 256 cells, one run each, every cell keeping its
// run's cumulative end so that all cells compare against a voxel index at
// once and the first cell past it claims the run. Each command passes in
// order through the linear index multiply (S_IDX1, S_IDX2), the cell
// lookup (S_FIND), the edit decision (S_DEC), the cells shifting or
// rewriting in parallel (S_APPLY) and the load of the output register
// (S_DONE). A new command is taken in the cycle after the result is
// loaded, so the block takes no new command while one is in flight. The
// load waits while the output register still holds a result the sink has
// not taken. Runs never written read back as anything; only runs below
// the run count are read.
`default_nettype none
module rle_array_point_write_core import rlepw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // cfg: index 0 chunk_edge, 1 default_voxel
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [VOX_W-1:0]  cfg_wdata_i,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // cmd[2:0] voxel_id[18:3] run_len_in[34:19] pos_x[39:35] pos_y[44:40]
  // pos_z[49:45] run_select[57:50], zero above
  input  wire logic [IN_W-1:0]   s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // status[1:0] voxel_out[17:2] len_out[33:18] runs_used[42:34] changed[43]
  output logic [OUT_W-1:0]       m_axis_tdata_o
);

  state_e state_q, state_d;

  logic [EDGE_W-1:0] edge_q;
  logic [VOX_W-1:0]  dflt_q;
  logic [CNT_W-1:0]  total_q;
  logic [LIM_W-1:0]  grand_q;

  logic [2:0]        cmd_q;
  logic [VOX_W-1:0]  vid_q;
  logic [LEN_W-1:0]  rlen_q;
  logic [CRD_W-1:0]  x_q, y_q, z_q;
  logic [POS_W-1:0]  sel_q;
  logic              bad_q;
  logic [T1_W-1:0]   t1_q;
  logic [LIM_W-1:0]  idx_q;

  logic              f_found_q;
  logic [POS_W-1:0]  f_pos_q;
  logic [VOX_W-1:0]  f_vox_q, f_nvox_q;
  logic [LEN_W-1:0]  f_len_q, f_nlen_q;
  logic [LIM_W-1:0]  f_start_q;

  ctl_t              ctl_q, ctl_d;
  logic [1:0]        rs_status_q, rs_status_d;
  logic [VOX_W-1:0]  rs_vox_q, rs_vox_d;
  logic [LEN_W-1:0]  rs_len_q, rs_len_d;
  logic              rs_chg_q, rs_chg_d;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  // Cell chain
  cell_t             own   [MAX_RUNS];
  cell_t             prev1 [MAX_RUNS];
  cell_t             prev2 [MAX_RUNS];
  cell_t             nxt   [MAX_RUNS];
  logic              hit   [MAX_RUNS];
  logic              phit  [MAX_RUNS];
  logic              pick  [MAX_RUNS];
  lk_t               lk;
  logic              apply;

  assign lk.idx   = idx_q;
  assign lk.total = total_q;
  assign lk.sel   = sel_q;
  assign lk.rd    = (cmd_q == CMD_READ);
  assign apply    = (state_q == S_APPLY) && (ctl_q.op != OP_NOP);

  for (genvar g = 0; g < MAX_RUNS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev1[g] = '0;
      assign prev2[g] = '0;
      assign phit[g]  = 1'b0;
    end else if (g == 1) begin : g_second
      assign prev1[g] = own[g-1];
      assign prev2[g] = '0;
      assign phit[g]  = hit[g-1];
    end else begin : g_rest
      assign prev1[g] = own[g-1];
      assign prev2[g] = own[g-2];
      assign phit[g]  = hit[g-1];
    end
    if (g == MAX_RUNS - 1) begin : g_last
      assign nxt[g] = '0;
    end else begin : g_inner
      assign nxt[g] = own[g+1];
    end

    rlepw_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (POS_W'(g)),
      .lk_i       (lk),
      .ctl_i      (ctl_q),
      .apply_i    (apply),
      .prev1_i    (prev1[g]),
      .prev2_i    (prev2[g]),
      .prev_hit_i (phit[g]),
      .own_o      (own[g]),
      .hit_o      (hit[g]),
      .pick_o     (pick[g])
    );
  end

  // Collect the picked cell and its successor
  logic             c_found;
  logic [POS_W-1:0] c_pos;
  cell_t            c_cur, c_nxt;

  always_comb begin
    c_found = 1'b0;
    c_pos   = '0;
    c_cur   = '0;
    c_nxt   = '0;
    for (int k = 0; k < MAX_RUNS; k++) begin
      if (pick[k]) begin
        c_found = 1'b1;
        c_pos   = c_pos | POS_W'(k);
        c_cur   = c_cur | own[k];
        c_nxt   = c_nxt | nxt[k];
      end
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Decide the edit from the located run
  logic [VOX_W-1:0] v;
  logic [LEN_W-1:0] rem;
  logic             n_valid, merge;
  logic [1:0]       need;
  op_e              w_op;

  always_comb begin
    v       = (cmd_q == CMD_REMOVE) ? dflt_q : vid_q;
    rem     = LEN_W'(idx_q - f_start_q);
    n_valid = ({1'b0, f_pos_q} + CNT_W'(1)) < total_q;
    merge   = n_valid && (f_nvox_q == v) && (f_nlen_q != LEN_FULL);
    if (rem == '0) begin
      w_op = OP_INS_BEFORE;
      need = 2'd1;
    end else if (rem == f_len_q - LEN_W'(1)) begin
      w_op = merge ? OP_TAIL_MERGE : OP_TAIL_INS;
      need = merge ? 2'd0 : 2'd1;
    end else begin
      w_op = OP_SPLIT;
      need = 2'd2;
    end

    ctl_d         = ctl_q;
    ctl_d.op      = OP_NOP;
    ctl_d.pos     = f_pos_q;
    ctl_d.rem     = rem;
    ctl_d.start   = f_start_q;
    ctl_d.vid     = v;
    ctl_d.rlen    = rlen_q;
    ctl_d.app_end = grand_q + LIM_W'(rlen_q);
    ctl_d.total   = total_q;
    rs_status_d   = ST_OK;
    rs_vox_d      = '0;
    rs_len_d      = '0;
    rs_chg_d      = 1'b0;
    case (cmd_q)
      CMD_APPEND: begin
        if (total_q == CNT_W'(MAX_RUNS)) begin
          rs_status_d = ST_FULL;
        end else begin
          ctl_d.op = OP_APPEND;
        end
      end
      CMD_READ: begin
        if (!f_found_q) begin
          rs_status_d = ST_BAD_RUN;
        end else begin
          rs_vox_d = f_vox_q;
          rs_len_d = f_len_q;
        end
      end
      CMD_WRITE, CMD_REMOVE: begin
        if (bad_q || !f_found_q) begin
          rs_status_d = ST_RANGE;
        end else if (f_vox_q != v) begin
          if (({1'b0, total_q} + (CNT_W + 1)'(need)) > (CNT_W + 1)'(MAX_RUNS)) begin
            rs_status_d = ST_FULL;
          end else begin
            ctl_d.op = w_op;
            rs_chg_d = 1'b1;
          end
        end
      end
      default: ctl_d.op = OP_NOP;
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_axis_tvalid_i) state_d = S_IDX1;
      S_IDX1:  state_d = S_IDX2;
      S_IDX2:  state_d = S_FIND;
      S_FIND:  state_d = S_DEC;
      S_DEC:   state_d = S_APPLY;
      S_APPLY: state_d = S_DONE;
      S_DONE:  if (!out_valid_q || m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= EDGE_RESET;
      dflt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EDGE: edge_q <= cfg_wdata_i[EDGE_W-1:0];
        CFG_DFLT: dflt_q <= cfg_wdata_i;
        default:  edge_q <= edge_q;
      endcase
    end
  end

  // Run count and total length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      grand_q <= '0;
    end else if (state_q == S_APPLY) begin
      if (cmd_q == CMD_CLEAR) begin
        total_q <= '0;
        grand_q <= '0;
      end else begin
        case (ctl_q.op)
          OP_APPEND: begin
            total_q <= total_q + CNT_W'(1);
            grand_q <= ctl_q.app_end;
          end
          OP_INS_BEFORE, OP_TAIL_INS: total_q <= total_q + CNT_W'(1);
          OP_SPLIT:                   total_q <= total_q + CNT_W'(2);
          default:                    total_q <= total_q;
        endcase
      end
    end
  end

  // Command payload, index and lookup capture
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q  <= s_axis_tdata_i[2:0];
      vid_q  <= s_axis_tdata_i[18:3];
      rlen_q <= s_axis_tdata_i[34:19];
      x_q    <= s_axis_tdata_i[39:35];
      y_q    <= s_axis_tdata_i[44:40];
      z_q    <= s_axis_tdata_i[49:45];
      sel_q  <= s_axis_tdata_i[57:50];
    end
    if (state_q == S_IDX1) begin
      t1_q  <= T1_W'(x_q * edge_q) + T1_W'(y_q);
      bad_q <= ({1'b0, x_q} >= edge_q) || ({1'b0, y_q} >= edge_q) ||
               ({1'b0, z_q} >= edge_q);
    end
    if (state_q == S_IDX2) begin
      idx_q <= LIM_W'(LIN_W'(t1_q * edge_q) + LIN_W'(z_q));
    end
    if (state_q == S_FIND) begin
      f_found_q <= c_found;
      f_pos_q   <= c_pos;
      f_vox_q   <= c_cur.vox;
      f_len_q   <= c_cur.len;
      f_start_q <= c_cur.lim - LIM_W'(c_cur.len);
      f_nvox_q  <= c_nxt.vox;
      f_nlen_q  <= c_nxt.len;
    end
    if (state_q == S_DEC) begin
      rs_status_q <= rs_status_d;
      rs_vox_q    <= rs_vox_d;
      rs_len_q    <= rs_len_d;
      rs_chg_q    <= rs_chg_d;
    end
  end

  // Edit command; op cleared at reset so no stray apply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (state_q == S_DEC) begin
      ctl_q <= ctl_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready_i)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready_i)) begin
      out_data_q <= {4'b0, rs_chg_q, total_q, rs_len_q, rs_vox_q, rs_status_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Testbench for rle_array_point_write_core: streams voxel-table commands,
// predicts every result from its own run table, and checks each transfer.
// Depends on rlepw_pkg and the core RTL.
`default_nettype none
module testbench import rlepw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;
  localparam int CYCLE_LIMIT = 600000;

  // Result fields from the lowest bit up: status first
  typedef struct packed {
    logic        changed;
    logic [8:0]  runs;
    logic [15:0] len;
    logic [15:0] vox;
    logic [1:0]  status;
  } table_reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [0:0]       cfg_idx_i = '0;
  logic [VOX_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  // Predictor state: the run table as the block should hold it
  logic [15:0]  run_vox_q [MAX_RUNS];
  logic [15:0]  run_len_q [MAX_RUNS];
  int unsigned  run_count;
  int unsigned  edge_len;
  logic [15:0]  empty_vox;

  table_reply_t pending_replies [$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           idle_on = 1'b1;

  rle_array_point_write_core u_top (.*);

  initial forever #4 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  // Shift runs from pos upward to open cnt slots
  function automatic void open_slots(input int unsigned pos, input int unsigned cnt);
    for (int i = int'(run_count) - 1; i >= int'(pos); i--) begin
      run_vox_q[i + cnt] = run_vox_q[i];
      run_len_q[i + cnt] = run_len_q[i];
    end
    run_count += cnt;
  endfunction

  function automatic status_e write_point(input int unsigned x, y, z,
                                          input logic [15:0] v, output logic chg);
    int unsigned rem, i, len, need;
    bit merge;
    chg = 1'b0;
    merge = 1'b0;
    i = 0;
    if (x >= edge_len || y >= edge_len || z >= edge_len) return ST_RANGE;
    rem = x * edge_len * edge_len + y * edge_len + z;
    while (i < run_count && run_len_q[i] <= rem) begin
      rem -= run_len_q[i];
      i++;
    end
    if (i >= run_count) return ST_RANGE;
    if (run_vox_q[i] == v) return ST_OK;
    len = run_len_q[i];
    if (rem == 0) need = 1;
    else if (rem == len - 1) begin
      merge = (i + 1 < run_count) && (run_vox_q[i + 1] == v) && (run_len_q[i + 1] < 16'hFFFF);
      need = merge ? 0 : 1;
    end else need = 2;
    if (run_count + need > MAX_RUNS) return ST_FULL;
    chg = 1'b1;
    if (rem == 0) begin
      run_len_q[i] = 16'(len - 1);
      open_slots(i, 1);
      run_vox_q[i] = v;
      run_len_q[i] = 16'd1;
    end else if (rem == len - 1) begin
      run_len_q[i] = 16'(len - 1);
      if (merge) run_len_q[i + 1] = run_len_q[i + 1] + 16'd1;
      else begin
        open_slots(i + 1, 1);
        run_vox_q[i + 1] = v;
        run_len_q[i + 1] = 16'd1;
      end
    end else begin
      run_len_q[i] = 16'(rem);
      open_slots(i + 1, 2);
      run_vox_q[i + 1] = v;
      run_len_q[i + 1] = 16'd1;
      run_vox_q[i + 2] = run_vox_q[i];
      run_len_q[i + 2] = 16'(len - rem - 1);
    end
    return ST_OK;
  endfunction

  function automatic table_reply_t predict_reply(input logic [2:0] cmd, input logic [15:0] vid,
      input logic [15:0] rlen, input logic [4:0] x, y, z, input logic [7:0] sel);
    table_reply_t r;
    logic chg;
    r = '0;
    chg = 1'b0;
    case (cmd)
      CMD_CLEAR: run_count = 0;
      CMD_APPEND: begin
        if (run_count >= MAX_RUNS) r.status = ST_FULL;
        else begin
          run_vox_q[run_count] = vid;
          run_len_q[run_count] = rlen;
          run_count++;
        end
      end
      CMD_WRITE:  r.status = write_point(x, y, z, vid, chg);
      CMD_REMOVE: r.status = write_point(x, y, z, empty_vox, chg);
      CMD_READ: begin
        if (sel >= run_count) r.status = ST_BAD_RUN;
        else begin
          r.vox = run_vox_q[sel];
          r.len = run_len_q[sel];
        end
      end
      default: ;
    endcase
    r.runs = run_count[8:0];
    r.changed = chg;
    return r;
  endfunction

  // Drive one command and hold it until the transfer
  task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] vid = '0,
      input logic [15:0] rlen = '0, input logic [4:0] x = '0, y = '0, z = '0,
      input logic [7:0] sel = '0);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'b0, sel, z, y, x, rlen, vid, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_replies.push_back(predict_reply(cmd, vid, rlen, x, y, z, sel));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write one register once the block is idle
  task automatic cfg_write(input logic [0:0] idx, input logic [15:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_EDGE) edge_len = value[5:0];
    else empty_vox = value;
  endtask

  // Check each result transfer against the oldest prediction
  initial begin
    int stall_left;
    table_reply_t got, want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[43:0];
        if (pending_replies.size() == 0) report("unexpected result", int'(got.runs), 0);
        else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status)
            report("status", int'(got.status), int'(want.status));
          if (got.vox !== want.vox) report("voxel_out", int'(got.vox), int'(want.vox));
          if (got.len !== want.len) report("len_out", int'(got.len), int'(want.len));
          if (got.runs !== want.runs) report("runs_used", int'(got.runs), int'(want.runs));
          if (got.changed !== want.changed)
            report("changed", int'(got.changed), int'(want.changed));
        end
        stall_left = idle_on ? $urandom_range(0, 19) : 0;
      end
      m_axis_tready_i <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Hand-picked cases on a 2x2x2 volume
  task automatic test_directed();
    cfg_write(CFG_EDGE, 16'd2);
    cfg_write(CFG_DFLT, 16'hFFFF);
    send_cmd(CMD_READ, .sel(8'd0));
    send_cmd(CMD_WRITE, .vid(16'd5));
    send_cmd(CMD_APPEND, .vid(16'd5), .rlen(16'd3));
    send_cmd(CMD_APPEND, .vid(16'd7), .rlen(16'd0));
    send_cmd(CMD_APPEND, .vid(16'd9), .rlen(16'd5));
    send_cmd(CMD_WRITE, .vid(16'd5), .z(5'd1));              // same voxel
    send_cmd(CMD_WRITE, .vid(16'd8));                        // insert before
    send_cmd(CMD_WRITE, .vid(16'd1), .y(5'd1), .z(5'd1));   // insert before
    send_cmd(CMD_WRITE, .vid(16'd9), .y(5'd1));              // tail, next is zero-length
    send_cmd(CMD_WRITE, .vid(16'd3), .x(5'd1), .y(5'd1), .z(5'd1)); // tail of last run
    send_cmd(CMD_REMOVE, .x(5'd1));
    send_cmd(CMD_WRITE, .vid(16'd4), .x(5'd2));              // out of range
    send_cmd(CMD_WRITE, .vid(16'd4), .x(5'd31), .y(5'd31), .z(5'd31));
    send_cmd(CMD_SPARE_A, .vid(16'hFFFF), .rlen(16'hFFFF));
    send_cmd(CMD_SPARE_B);
    send_cmd(CMD_SPARE_C, .sel(8'hFF));
    for (int i = 0; i < 7; i++) send_cmd(CMD_READ, .sel(i[7:0]));
    send_cmd(CMD_READ, .sel(8'hFF));
    // merge blocked by a next run already at full length
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_APPEND, .vid(16'd1), .rlen(16'd2));
    send_cmd(CMD_APPEND, .vid(16'd2), .rlen(16'hFFFF));
    send_cmd(CMD_WRITE, .vid(16'd2), .z(5'd1));
    send_cmd(CMD_READ, .sel(8'd2));
    send_cmd(CMD_WRITE, .vid(16'd7), .x(5'd1), .y(5'd1)); // index past summed lengths? no: in run 2
  endtask

  // Fill all slots, then try to grow the table
  task automatic test_table_full();
    cfg_write(CFG_EDGE, 16'd16);
    send_cmd(CMD_CLEAR);
    for (int i = 0; i < MAX_RUNS; i++)
      send_cmd(CMD_APPEND, .vid(16'($urandom_range(0, 3))), .rlen(16'd16));
    send_cmd(CMD_APPEND, .vid(16'd1), .rlen(16'd1));
    for (int i = 0; i < 12; i++)
      send_cmd(CMD_WRITE, .vid(16'($urandom)), .x(5'($urandom_range(0, 15))),
               .y(5'($urandom_range(0, 15))), .z(5'($urandom_range(0, 15))));
    send_cmd(CMD_READ, .sel(8'hFF));
  endtask

  function automatic logic [15:0] pick_vid();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return empty_vox;
      default: return 16'($urandom_range(1, 3));
    endcase
  endfunction

  // One setting: cover the volume with random runs, then random edits
  task automatic test_random_setting(input logic [5:0] e, input logic [15:0] dflt, input int items);
    int unsigned vol, rem, l, top, pick;
    cfg_write(CFG_EDGE, 16'(e));
    cfg_write(CFG_DFLT, dflt);
    idle_on = ($urandom_range(0, 3) != 0);
    vol = e * e * e;
    rem = vol;
    send_cmd(CMD_CLEAR);
    for (int n = 0; n < 10 && rem > 0; n++) begin
      l = $urandom_range(0, (rem > 65535) ? 65535 : rem);
      if ($urandom_range(0, 1)) l = l / 8;
      send_cmd(CMD_APPEND, .vid(pick_vid()), .rlen(16'(l)));
      rem -= l;
    end
    while (rem > 0) begin
      l = (rem > 65535) ? 65535 : rem;
      send_cmd(CMD_APPEND, .vid(pick_vid()), .rlen(16'(l)));
      rem -= l;
    end
    if (vol == 0) send_cmd(CMD_APPEND, .vid(pick_vid()), .rlen(16'($urandom)));
    top = (e == 0) ? 0 : ((e > 32) ? 31 : e - 1);
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)
        send_cmd((pick < 55) ? CMD_WRITE : CMD_REMOVE, .vid(pick_vid()),
                 .x(5'($urandom_range(0, top))), .y(5'($urandom_range(0, top))),
                 .z(5'($urandom_range(0, top))), .rlen(16'($urandom)));
      else if (pick < 87)
        send_cmd(CMD_READ, .sel($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 8))));
      else if (pick < 91)
        send_cmd(CMD_APPEND, .vid(16'($urandom)), .rlen(16'($urandom)));
      else if (pick < 96)
        send_cmd(CMD_WRITE, .vid(16'($urandom)), .x(5'($urandom)), .y(5'($urandom)),
                 .z(5'($urandom)));
      else
        send_cmd(3'($urandom_range(5, 7)), .vid(16'($urandom)), .rlen(16'($urandom)),
                 .sel(8'($urandom)));
    end
  endtask

  initial begin
    empty_vox = '0;
    edge_len = 16;
    run_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random_setting(6'd1, 16'h0000, 20);
    test_random_setting(6'd2, 16'hFFFF, 25);
    test_random_setting(6'd3, 16'h0002, 25);
    test_random_setting(6'd4, 16'($urandom), 25);
    test_random_setting(6'd32, 16'h0001, 30);
    test_random_setting(6'd32, 16'h0000, 20);
    test_random_setting(6'd63, 16'h0003, 25);
    test_random_setting(6'd0, 16'($urandom), 15);
    test_random_setting(6'($urandom_range(5, 31)), 16'($urandom), 25);
    drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
